// ===== sv/timed_line_floor_lookup_unit_macros.svh =====
// Assertion macros used by the datapath of the timed line floor lookup unit.
`ifndef TIMED_LINE_FLOOR_LOOKUP_UNIT_MACROS_SVH
`define TIMED_LINE_FLOOR_LOOKUP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TLFL_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TLFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TLFL_ASSERT(lbl, cond, msg)
`define TLFL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/tlfl_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types.
`default_nettype none
package tlfl_pkg;

    localparam int TLFL_MAX_LINES = 256;
    localparam int TLFL_TIME_BITS = 24;

    localparam int OP_W         = 2;
    localparam int ENTRY_TIME_W = 24;
    localparam int TEXT_REF_W   = 16;
    localparam int POSITION_W   = 48;
    localparam int LINE_INDEX_W = 8;
    localparam int NS_PER_CS_W  = 24;

    localparam logic [NS_PER_CS_W-1:0] NS_PER_CS = 24'd10_000_000;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic latch;
        logic clr;
        logic set_full;
        logic srch_init;
        logic srch_rd;
        logic srch_mul;
        logic srch_cmp;
        logic shift_step;
        logic place;
        logic q_rd0;
        logic q_rd1;
        logic q_nxt;
        logic out_load;
    } tlfl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            active;
        logic            count_zero;
        logic            full;
        logic            lo_lt_hi;
        logic            lo_zero;
        logic            lo_ge_count;
        logic            k_gt_lo;
        logic            pend;
        logic            out_busy;
    } tlfl_sts_t;

endpackage
`default_nettype wire

// ===== sv/tlfl_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module tlfl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/tlfl_ctrl.sv =====
// Controller state machine sequencing clear, insert and query transactions.
`default_nettype none
module tlfl_ctrl import tlfl_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire tlfl_sts_t sts,
    output tlfl_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_PLACE = 4'd6;
    localparam logic [3:0] S_QRD0  = 4'd7;
    localparam logic [3:0] S_QRD1  = 4'd8;
    localparam logic [3:0] S_QNXT  = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clr    = 1'b1;
                        state_next = S_RESP;
                    end
                    OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_full = 1'b1;
                            state_next   = S_RESP;
                        end
                        else
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!sts.active || sts.count_zero)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_MUL;
                end
                else if (sts.op == OP_INSERT)
                begin
                    state_next = S_SHIFT;
                end
                else if (sts.lo_zero)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_QRD0;
                end
            end
            S_MUL:
            begin
                cmd.srch_mul = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH;
            end
            S_SHIFT:
            begin
                if (sts.k_gt_lo)
                begin
                    cmd.shift_step = 1'b1;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                if (!sts.pend)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_QRD0:
            begin
                cmd.q_rd0  = 1'b1;
                state_next = S_QRD1;
            end
            S_QRD1:
            begin
                cmd.q_rd1  = 1'b1;
                state_next = sts.lo_ge_count ? S_RESP : S_QNXT;
            end
            S_QNXT:
            begin
                cmd.q_nxt  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tlfl_dp.sv =====
// Datapath: line table RAM, search bounds, entry shifter and result register.
`default_nettype none
`include "timed_line_floor_lookup_unit_macros.svh"
module tlfl_dp import tlfl_pkg::*; #(
    parameter int MAX_LINES = TLFL_MAX_LINES,
    parameter int TIME_BITS = TLFL_TIME_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tlfl_cmd_t               cmd,
    output tlfl_sts_t                    sts,
    input  wire logic [OP_W-1:0]         operation,
    input  wire logic [ENTRY_TIME_W-1:0] entry_time,
    input  wire logic [TEXT_REF_W-1:0]   entry_text_ref,
    input  wire logic [POSITION_W-1:0]   position_ns,
    input  wire logic                    player_active,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         found,
    output logic [LINE_INDEX_W-1:0]      line_index,
    output logic [TEXT_REF_W-1:0]        line_text_ref,
    output logic [ENTRY_TIME_W-1:0]      line_start,
    output logic [ENTRY_TIME_W-1:0]      line_length,
    output logic                         final_line,
    output logic                         table_full
);

    localparam int AW     = $clog2(MAX_LINES);
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int RAM_W  = TIME_BITS + TEXT_REF_W;
    localparam int PROD_W = TIME_BITS + NS_PER_CS_W;
    localparam int CMP_W  = (PROD_W > POSITION_W) ? PROD_W : POSITION_W;
    localparam int EXT_W  = (TIME_BITS > ENTRY_TIME_W) ? TIME_BITS : ENTRY_TIME_W;
    localparam int IDX_W  = (CNT_W > LINE_INDEX_W) ? CNT_W : LINE_INDEX_W;

    logic [OP_W-1:0]       op_reg;
    logic [TIME_BITS-1:0]  time_reg;
    logic [TEXT_REF_W-1:0] text_reg;
    logic [POSITION_W-1:0] ns_reg;
    logic                  active_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      lo_reg;
    logic [CNT_W-1:0]      hi_reg;
    logic [CNT_W-1:0]      k_reg;
    logic                  pend_reg;
    logic [AW-1:0]         pend_addr_reg;

    logic [TIME_BITS-1:0]  samp_start_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [TIME_BITS-1:0]  cur_start_reg;
    logic [TEXT_REF_W-1:0] cur_text_reg;
    logic [TIME_BITS-1:0]  next_start_reg;
    logic                  found_reg;
    logic                  final_reg;
    logic                  full_reg;
    logic                  out_valid_reg;

    logic [EXT_W-1:0]      t_ext;
    logic [CNT_W-1:0]      mid;
    logic [CNT_W-1:0]      k_m1;
    logic [CNT_W-1:0]      lo_m1;
    logic                  le;
    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [RAM_W-1:0]      wdata;
    logic [RAM_W-1:0]      rdata;
    logic [TIME_BITS-1:0]  rd_start;
    logic [TEXT_REF_W-1:0] rd_text;
    logic [TIME_BITS-1:0]  diff;
    logic [EXT_W-1:0]      diff_ext;
    logic [EXT_W-1:0]      cur_ext;
    logic [IDX_W-1:0]      idx_ext;

    assign t_ext    = EXT_W'(entry_time);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign k_m1     = k_reg - CNT_W'(1);
    assign lo_m1    = lo_reg - CNT_W'(1);
    assign rd_start = rdata[RAM_W-1:TEXT_REF_W];
    assign rd_text  = rdata[TEXT_REF_W-1:0];
    assign diff     = next_start_reg - cur_start_reg;
    assign diff_ext = EXT_W'(diff);
    assign cur_ext  = EXT_W'(cur_start_reg);
    assign idx_ext  = IDX_W'(lo_m1);

    assign le = (op_reg == OP_QUERY) ? (CMP_W'(prod_reg) <= CMP_W'(ns_reg))
                                     : (samp_start_reg <= time_reg);

    always_comb
    begin
        raddr = '0;
        if (cmd.srch_rd)
        begin
            raddr = mid[AW-1:0];
        end
        else if (cmd.shift_step)
        begin
            raddr = k_m1[AW-1:0];
        end
        else if (cmd.q_rd0)
        begin
            raddr = lo_m1[AW-1:0];
        end
        else if (cmd.q_rd1)
        begin
            raddr = lo_reg[AW-1:0];
        end
    end

    // a pending shift write always wins; placement waits for it
    assign we    = pend_reg || cmd.place;
    assign waddr = pend_reg ? pend_addr_reg : lo_reg[AW-1:0];
    assign wdata = pend_reg ? rdata : {time_reg, text_reg};

    tlfl_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_LINES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            final_reg     <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.shift_step;
            if (cmd.latch)
            begin
                found_reg <= 1'b0;
                final_reg <= 1'b0;
                full_reg  <= 1'b0;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
            if (cmd.clr)
            begin
                count_reg <= '0;
                lo_reg    <= '0;
                hi_reg    <= '0;
            end
            if (cmd.srch_init)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
                k_reg  <= count_reg;
            end
            if (cmd.srch_cmp)
            begin
                if (le)
                begin
                    lo_reg <= mid + CNT_W'(1);
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (cmd.shift_step)
            begin
                k_reg <= k_m1;
            end
            if (cmd.place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.q_rd1)
            begin
                found_reg <= 1'b1;
                final_reg <= (lo_reg >= count_reg);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= operation;
            time_reg   <= t_ext[TIME_BITS-1:0];
            text_reg   <= entry_text_ref;
            ns_reg     <= position_ns;
            active_reg <= player_active;
        end
        if (cmd.shift_step)
        begin
            pend_addr_reg <= k_reg[AW-1:0];
        end
        if (cmd.srch_mul)
        begin
            samp_start_reg <= rd_start;
            prod_reg       <= PROD_W'(rd_start) * PROD_W'(NS_PER_CS);
        end
        if (cmd.q_rd1)
        begin
            cur_start_reg <= rd_start;
            cur_text_reg  <= rd_text;
        end
        if (cmd.q_nxt)
        begin
            next_start_reg <= rd_start;
        end
        if (cmd.out_load)
        begin
            found         <= found_reg;
            line_index    <= found_reg ? idx_ext[LINE_INDEX_W-1:0] : '0;
            line_text_ref <= found_reg ? cur_text_reg : '0;
            line_start    <= found_reg ? cur_ext[ENTRY_TIME_W-1:0] : '0;
            if (!found_reg)
            begin
                line_length <= '0;
            end
            else if (final_reg)
            begin
                line_length <= '1;
            end
            else
            begin
                line_length <= diff_ext[ENTRY_TIME_W-1:0];
            end
            final_line <= found_reg && final_reg;
            table_full <= full_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.op          = op_reg;
    assign sts.active      = active_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.full        = (count_reg >= CNT_W'(MAX_LINES));
    assign sts.lo_lt_hi    = (lo_reg < hi_reg);
    assign sts.lo_zero     = (lo_reg == '0);
    assign sts.lo_ge_count = (lo_reg >= count_reg);
    assign sts.k_gt_lo     = (k_reg > lo_reg);
    assign sts.pend        = pend_reg;
    assign sts.out_busy    = out_valid_reg && out_stall;

    `TLFL_ASSERT(a_count_range, count_reg <= CNT_W'(MAX_LINES), "entry count beyond table size")
    `TLFL_ASSERT(a_search_bounds, lo_reg <= hi_reg && hi_reg <= count_reg, "search bounds broken")
    `TLFL_ASSERT(a_one_write, !(pend_reg && cmd.place), "shift write collides with placement")
    `TLFL_ASSERT_NEXT(a_place_grows, cmd.place, count_reg == $past(count_reg) + CNT_W'(1), "count did not grow")

endmodule
`default_nettype wire

// ===== sv/timed_line_floor_lookup_unit.sv =====
// Top level of the timed line floor lookup unit.
`default_nettype none
// Keeps up to MAX_LINES timed lines sorted by start time in one RAM and takes one
// transaction at a time; each transaction yields exactly one result. An insert
// first runs a binary search, each step being a RAM read, a multiply and a
// compare, then moves every line above the sorted place of the new line up by one
// through the single RAM write port. A query runs the same search; the position
// is compared as start * 10000000 against the nanosecond value, so no divider is
// needed. A query on an inactive player or an empty table, and an insert into a
// full table, skip the search and go straight to the result. The next transaction
// is accepted once the result is in the output register, even while it is still
// stalled. Table contents are undefined after reset; only lines below the entry
// count are ever used.
module timed_line_floor_lookup_unit import tlfl_pkg::*; #(
    parameter int MAX_LINES = TLFL_MAX_LINES,
    parameter int TIME_BITS = TLFL_TIME_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [OP_W-1:0]         operation,
    input  wire logic [ENTRY_TIME_W-1:0] entry_time,
    input  wire logic [TEXT_REF_W-1:0]   entry_text_ref,
    input  wire logic [POSITION_W-1:0]   position_ns,
    input  wire logic                    player_active,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         found,
    output logic [LINE_INDEX_W-1:0]      line_index,
    output logic [TEXT_REF_W-1:0]        line_text_ref,
    output logic [ENTRY_TIME_W-1:0]      line_start,
    output logic [ENTRY_TIME_W-1:0]      line_length,
    output logic                         final_line,
    output logic                         table_full
);

    tlfl_cmd_t cmd;
    tlfl_sts_t sts;

    tlfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlfl_dp #(
        .MAX_LINES (MAX_LINES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (operation),
        .entry_time     (entry_time),
        .entry_text_ref (entry_text_ref),
        .position_ns    (position_ns),
        .player_active  (player_active),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .line_index     (line_index),
        .line_text_ref  (line_text_ref),
        .line_start     (line_start),
        .line_length    (line_length),
        .final_line     (final_line),
        .table_full     (table_full)
    );

endmodule
`default_nettype wire
